>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the crossover block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define MCSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcsr: implication check failed");

// next-cycle implication, masked while reset is high
`define MCSR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcsr: next-cycle check failed");

// state in the cycle after reset
`define MCSR_ASSERT_RST(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("mcsr: post-reset check failed");

`endif

>>> sv/mcsr_pkg.sv
// ----------------------------------------------------------------------------
// mcsr_pkg
// Types, constants and helpers shared by the crossover signal/return block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcsr_pkg;

   localparam int PRICE_W   = 32;
   localparam int RET_W     = 32;
   localparam int GROWTH_W  = 48;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 4;
   localparam int FRAC_BITS = 24;

   localparam int MAX_WINDOW_DEF = 256;

   localparam logic [CFG_W-1:0] SHORT_RESET = CFG_W'(60);
   localparam logic [CFG_W-1:0] LONG_RESET  = CFG_W'(250);

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LONG  = CSR_IDX_W'(1);

   localparam logic [RET_W-1:0]    Q24_ONE    = 32'h0100_0000;
   localparam logic [RET_W-1:0]    RET_MAX    = 32'h7FFF_FFFF;
   localparam logic [GROWTH_W-1:0] GROWTH_ONE = 48'h0001_0000_0000;
   localparam logic [GROWTH_W-1:0] GROWTH_MAX = 48'hFFFF_FFFF_FFFF;

   // restoring divider: dividend is the price change shifted up by FRAC_BITS
   localparam int DIV_BITS   = PRICE_W + FRAC_BITS;
   localparam int DIV_PER_CY = 2;
   localparam int DIV_CYCLES = DIV_BITS / DIV_PER_CY;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic               series_start;
   } req_type;

   typedef struct packed {
      logic                    long_signal;
      logic signed [RET_W-1:0] daily_return;
      logic [GROWTH_W-1:0]     growth_factor;
      logic                    divide_error;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_LOAD,
      CMD_ADD,
      CMD_SCAN,
      CMD_MUL,
      CMD_CMP,
      CMD_DIV,
      CMD_RET,
      CMD_GLO,
      CMD_GHI,
      CMD_GFIN,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic dirty;
      logic scan_done;
      logic need_ret;
      logic div_last;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic [PRICE_W-1:0]  rem;
      logic [DIV_BITS-1:0] dq;
   } div_type;

   // one restoring step: shift in a dividend bit, shift out a quotient bit
   function automatic div_type div_step(div_type s, logic [PRICE_W-1:0] d);
      logic [PRICE_W:0] t;
      logic             ge;
      div_type          r;
      t     = {s.rem, s.dq[DIV_BITS-1]};
      ge    = (t >= {1'b0, d});
      r.rem = ge ? PRICE_W'(t - {1'b0, d}) : t[PRICE_W-1:0];
      r.dq  = {s.dq[DIV_BITS-2:0], ge};
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/mcsr_ctrl.sv
// ----------------------------------------------------------------------------
// mcsr_ctrl
// Sequencer: steps one item through load, sums, compare, divide and growth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               csr_ready,
   output mcsr_pkg::cmd_type  cmd,
   input  mcsr_pkg::stat_type stat
);
   import mcsr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ADD,
      ST_SCAN,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_RET,
      ST_GLO,
      ST_GHI,
      ST_GFIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      stall_in = stall_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd      = CMD_ACCEPT;
               stall_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd      = CMD_LOAD;
            state_in = stat.dirty ? ST_SCAN : ST_ADD;
         end
         ST_ADD: begin
            cmd      = CMD_ADD;
            state_in = ST_MUL;
         end
         ST_SCAN: begin
            cmd = CMD_SCAN;
            if (stat.scan_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd      = CMD_MUL;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd      = CMD_CMP;
            state_in = stat.need_ret ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd = CMD_DIV;
            if (stat.div_last) begin
               state_in = ST_RET;
            end
         end
         ST_RET: begin
            cmd      = CMD_RET;
            state_in = ST_GLO;
         end
         ST_GLO: begin
            cmd      = CMD_GLO;
            state_in = ST_GHI;
         end
         ST_GHI: begin
            cmd      = CMD_GHI;
            state_in = ST_GFIN;
         end
         ST_GFIN: begin
            cmd      = CMD_GFIN;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (stat.out_free) begin
               cmd      = CMD_FINISH;
               stall_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            stall_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;
   assign csr_ready = !stall_ff;

endmodule

`default_nettype wire

>>> sv/mcsr_dpath.sv
// ----------------------------------------------------------------------------
// mcsr_dpath
// Delay line, window sums, crossover compare, return divider and growth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsr_dpath #(
   parameter int MAX_WINDOW = mcsr_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mcsr_pkg::cmd_type                cmd,
   output mcsr_pkg::stat_type               stat,
   input  mcsr_pkg::req_type                req_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mcsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mcsr_pkg::CFG_W-1:0]       csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mcsr_pkg::rsp_type                rsp_data
);
   import mcsr_pkg::*;

   localparam int AW     = $clog2(MAX_WINDOW);
   localparam int WW     = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = PRICE_W + AW;
   localparam int PROD_W = SUM_W + WW;
   localparam int MUL_W  = FRAC_BITS + RET_W;
   localparam int HALF_W = GROWTH_W - FRAC_BITS;

   // delay line
   logic [PRICE_W-1:0] hist_mem [MAX_WINDOW];
   logic [PRICE_W-1:0] rd0_ff, rd1_ff;
   logic [AW-1:0]      rd_addr0, rd_addr1;
   logic               mem_we;

   logic [CFG_W-1:0]   short_ff, short_in, long_ff, long_in;
   logic               dirty_ff, dirty_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [WW-1:0]      samples_ff, samples_in;
   logic [SUM_W-1:0]   sum_s_ff, sum_s_in, sum_l_ff, sum_l_in;
   logic [PRICE_W-1:0] last_price_ff, last_price_in;
   logic               last_sig_ff, last_sig_in;
   logic [GROWTH_W-1:0] growth_ff, growth_in;
   logic               have_prev_ff, have_prev_in;
   logic               drop_s_ff, drop_s_in, drop_l_ff, drop_l_in;
   logic [WW-1:0]      scan_k_ff, scan_k_in, scan_pk_ff, scan_pk_in;
   logic               scan_v_ff, scan_v_in;
   logic [PROD_W-1:0]  prod_s_ff, prod_s_in, prod_l_ff, prod_l_in;
   logic               sig_ff, sig_in;
   logic               neg_ff, neg_in;
   div_type            div_ff, div_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [RET_W-1:0]   ret_ff, ret_in;
   logic [RET_W-1:0]   fac_ff, fac_in;
   logic [MUL_W-1:0]   plo_ff, plo_in, phi_ff, phi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // effective windows and derived addresses
   logic [WW-1:0]      ws, wl, scan_len;
   logic [WW:0]        t_s, t_l, t_scan;
   logic [AW-1:0]      addr_s, addr_l, addr_scan;
   logic [PRICE_W-1:0] diff;
   div_type            div_mid, div_nxt;
   logic [HALF_W-1:0]  mul_a;
   logic [MUL_W-1:0]   mul_p;
   logic [MUL_W:0]     gsum;
   logic [RET_W-1:0]   mag;

   always_comb begin
      if (short_ff == '0) begin
         ws = WW'(1);
      end else if (32'(short_ff) > 32'(MAX_WINDOW)) begin
         ws = WW'(MAX_WINDOW);
      end else begin
         ws = WW'(short_ff);
      end
      if (long_ff == '0) begin
         wl = WW'(1);
      end else if (32'(long_ff) > 32'(MAX_WINDOW)) begin
         wl = WW'(MAX_WINDOW);
      end else begin
         wl = WW'(long_ff);
      end
   end

   assign scan_len = (ws > wl) ? ws : wl;

   // slot that leaves each window: written w items before the current slot
   assign t_s    = (WW+1)'(pos_ff) + (WW+1)'(MAX_WINDOW) - (WW+1)'(ws);
   assign t_l    = (WW+1)'(pos_ff) + (WW+1)'(MAX_WINDOW) - (WW+1)'(wl);
   // newest first, counting back from the slot just written
   assign t_scan = (WW+1)'(pos_ff) + (WW+1)'(MAX_WINDOW - 1) - (WW+1)'(scan_k_ff);

   assign addr_s    = (t_s >= (WW+1)'(MAX_WINDOW)) ? AW'(t_s - (WW+1)'(MAX_WINDOW))
                                                   : AW'(t_s);
   assign addr_l    = (t_l >= (WW+1)'(MAX_WINDOW)) ? AW'(t_l - (WW+1)'(MAX_WINDOW))
                                                   : AW'(t_l);
   assign addr_scan = (t_scan >= (WW+1)'(MAX_WINDOW))
                      ? AW'(t_scan - (WW+1)'(MAX_WINDOW)) : AW'(t_scan);

   assign rd_addr0 = (cmd == CMD_SCAN) ? addr_scan : addr_s;
   assign rd_addr1 = addr_l;
   assign mem_we   = (cmd == CMD_LOAD);

   // read before write: a full-depth window sees the slot's old price
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[pos_ff] <= price_ff;
      end
      rd0_ff <= hist_mem[rd_addr0];
      rd1_ff <= hist_mem[rd_addr1];
   end

   assign diff    = (price_ff >= last_price_ff) ? (price_ff - last_price_ff)
                                                : (last_price_ff - price_ff);
   assign div_mid = div_step(div_ff, last_price_ff);
   assign div_nxt = div_step(div_mid, last_price_ff);

   assign mul_a = (cmd == CMD_GHI) ? growth_ff[GROWTH_W-1:FRAC_BITS]
                                   : HALF_W'(growth_ff[FRAC_BITS-1:0]);
   assign mul_p = MUL_W'(mul_a) * MUL_W'(fac_ff);
   assign gsum  = (MUL_W+1)'(phi_ff) + (MUL_W+1)'(plo_ff >> FRAC_BITS);

   assign mag = (div_ff.dq > DIV_BITS'(RET_MAX)) ? RET_MAX : div_ff.dq[RET_W-1:0];

   always_comb begin
      short_in      = short_ff;
      long_in       = long_ff;
      dirty_in      = dirty_ff;
      price_in      = price_ff;
      pos_in        = pos_ff;
      samples_in    = samples_ff;
      sum_s_in      = sum_s_ff;
      sum_l_in      = sum_l_ff;
      last_price_in = last_price_ff;
      last_sig_in   = last_sig_ff;
      growth_in     = growth_ff;
      have_prev_in  = have_prev_ff;
      drop_s_in     = drop_s_ff;
      drop_l_in     = drop_l_ff;
      scan_k_in     = scan_k_ff;
      scan_pk_in    = scan_pk_ff;
      scan_v_in     = scan_v_ff;
      prod_s_in     = prod_s_ff;
      prod_l_in     = prod_l_ff;
      sig_in        = sig_ff;
      neg_in        = neg_ff;
      div_in        = div_ff;
      div_cnt_in    = div_cnt_ff;
      ret_in        = ret_ff;
      fac_in        = fac_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SHORT: begin
               short_in = csr_wdata;
               dirty_in = 1'b1;
            end
            CSR_LONG: begin
               long_in  = csr_wdata;
               dirty_in = 1'b1;
            end
            default: begin
            end
         endcase
      end

      case (cmd)
         CMD_ACCEPT: begin
            price_in = req_data.price;
            if (req_data.series_start) begin
               pos_in        = '0;
               samples_in    = '0;
               sum_s_in      = '0;
               sum_l_in      = '0;
               last_price_in = '0;
               last_sig_in   = 1'b0;
               growth_in     = GROWTH_ONE;
            end
         end
         CMD_LOAD: begin
            have_prev_in = (samples_ff != '0);
            drop_s_in    = (samples_ff >= ws);
            drop_l_in    = (samples_ff >= wl);
            pos_in       = (pos_ff == AW'(MAX_WINDOW - 1)) ? '0 : pos_ff + AW'(1);
            if (samples_ff != WW'(MAX_WINDOW)) begin
               samples_in = samples_ff + WW'(1);
            end
            if (dirty_ff) begin
               scan_k_in = '0;
               scan_v_in = 1'b0;
               sum_s_in  = '0;
               sum_l_in  = '0;
            end
         end
         CMD_ADD: begin
            sum_s_in = sum_s_ff + SUM_W'(price_ff) - (drop_s_ff ? SUM_W'(rd0_ff) : '0);
            sum_l_in = sum_l_ff + SUM_W'(price_ff) - (drop_l_ff ? SUM_W'(rd1_ff) : '0);
         end
         CMD_SCAN: begin
            if (scan_k_ff < scan_len) begin
               scan_k_in  = scan_k_ff + WW'(1);
               scan_pk_in = scan_k_ff;
               scan_v_in  = 1'b1;
            end else begin
               scan_v_in = 1'b0;
            end
            if (scan_v_ff && (scan_pk_ff < samples_ff)) begin
               if (scan_pk_ff < ws) begin
                  sum_s_in = sum_s_ff + SUM_W'(rd0_ff);
               end
               if (scan_pk_ff < wl) begin
                  sum_l_in = sum_l_ff + SUM_W'(rd0_ff);
               end
            end
            if ((scan_k_ff == scan_len) && !scan_v_ff) begin
               dirty_in = 1'b0;
            end
         end
         CMD_MUL: begin
            prod_s_in = PROD_W'(sum_s_ff) * PROD_W'(wl);
            prod_l_in = PROD_W'(sum_l_ff) * PROD_W'(ws);
         end
         CMD_CMP: begin
            sig_in     = (samples_ff >= ws) && (samples_ff >= wl) && (prod_s_ff > prod_l_ff);
            ret_in     = '0;
            neg_in     = (price_ff < last_price_ff);
            div_in.rem = '0;
            div_in.dq  = {diff, FRAC_BITS'(0)};
            div_cnt_in = DIV_CNT_W'(DIV_CYCLES);
         end
         CMD_DIV: begin
            div_in     = div_nxt;
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
         end
         CMD_RET: begin
            // a fall never reaches one whole unit, so only a rise saturates
            if (neg_ff) begin
               ret_in = RET_W'(0) - div_ff.dq[RET_W-1:0];
               fac_in = Q24_ONE - div_ff.dq[RET_W-1:0];
            end else begin
               ret_in = mag;
               fac_in = Q24_ONE + mag;
            end
         end
         CMD_GLO: begin
            plo_in = mul_p;
         end
         CMD_GHI: begin
            phi_in = mul_p;
         end
         CMD_GFIN: begin
            growth_in = (gsum > (MUL_W+1)'(GROWTH_MAX)) ? GROWTH_MAX
                                                         : gsum[GROWTH_W-1:0];
         end
         CMD_FINISH: begin
            rsp_valid_in              = 1'b1;
            rsp_in.long_signal        = sig_ff;
            rsp_in.daily_return       = $signed(ret_ff);
            rsp_in.growth_factor      = growth_ff;
            rsp_in.divide_error       = have_prev_ff && (last_price_ff == '0);
            last_price_in             = price_ff;
            last_sig_in               = sig_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff      <= SHORT_RESET;
         long_ff       <= LONG_RESET;
         dirty_ff      <= 1'b0;
         pos_ff        <= '0;
         samples_ff    <= '0;
         sum_s_ff      <= '0;
         sum_l_ff      <= '0;
         last_price_ff <= '0;
         last_sig_ff   <= 1'b0;
         growth_ff     <= GROWTH_ONE;
         have_prev_ff  <= 1'b0;
         scan_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         short_ff      <= short_in;
         long_ff       <= long_in;
         dirty_ff      <= dirty_in;
         pos_ff        <= pos_in;
         samples_ff    <= samples_in;
         sum_s_ff      <= sum_s_in;
         sum_l_ff      <= sum_l_in;
         last_price_ff <= last_price_in;
         last_sig_ff   <= last_sig_in;
         growth_ff     <= growth_in;
         have_prev_ff  <= have_prev_in;
         scan_v_ff     <= scan_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff   <= price_in;
      drop_s_ff  <= drop_s_in;
      drop_l_ff  <= drop_l_in;
      scan_k_ff  <= scan_k_in;
      scan_pk_ff <= scan_pk_in;
      prod_s_ff  <= prod_s_in;
      prod_l_ff  <= prod_l_in;
      sig_ff     <= sig_in;
      neg_ff     <= neg_in;
      div_ff     <= div_in;
      div_cnt_ff <= div_cnt_in;
      ret_ff     <= ret_in;
      fac_ff     <= fac_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      rsp_ff     <= rsp_in;
   end

   assign stat.dirty     = dirty_ff;
   assign stat.scan_done = (scan_k_ff == scan_len) && !scan_v_ff;
   assign stat.need_ret  = have_prev_ff && (last_price_ff != '0) && last_sig_ff;
   assign stat.div_last  = (div_cnt_ff == DIV_CNT_W'(1));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> sv/ma_crossover_signal_return_unit.sv
// ----------------------------------------------------------------------------
// ma_crossover_signal_return_unit
// Takes one price per transfer and returns one result per price: the long
// signal of a short/long moving-average crossover, the day's return earned on
// the previous signal, and the running growth factor. Items are worked one at
// a time. An item is loaded, summed, multiplied and compared. When the
// previous signal was long and the previous price was nonzero, it then goes
// through the restoring divider, which retires two quotient bits a cycle,
// and the growth multiply, split into low-half, high-half and final-sum
// steps over one 24x32 multiplier. The first item after a window register
// write rebuilds both sums from the price delay line, one read a cycle,
// reading max(short, long) entries in place of the single add step. The
// delay line is a MAX_WINDOW-entry memory with no clearing pass after reset.
// A finished result sits in the output register, so the next price is taken
// while it waits. Window registers are written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ma_crossover_signal_return_unit #(
   parameter int MAX_WINDOW = mcsr_pkg::MAX_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mcsr_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mcsr_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mcsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcsr_pkg::CFG_W-1:0]     csr_wdata
);
   import mcsr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mcsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   mcsr_dpath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> sv/mcsr_checker.sv
// ----------------------------------------------------------------------------
// mcsr_checker
// Port-level checks on the crossover block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mcsr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input mcsr_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input mcsr_pkg::rsp_type              rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [mcsr_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [mcsr_pkg::CFG_W-1:0]     csr_wdata
);

   // a stalled result holds until transfer
   `MCSR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // one item in flight: a transfer closes the input until its result is placed in the output register
   `MCSR_ASSERT_NXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall && csr_ready == 1'b0)

   // a zero previous price forces a zero return
   `MCSR_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_data.divide_error, rsp_data.daily_return == 32'sd0)

   // reset leaves the block empty and open
   `MCSR_ASSERT_RST(a_reset_idle, clock, reset, !rsp_valid && !req_stall && csr_ready)

endmodule

bind ma_crossover_signal_return_unit mcsr_checker u_mcsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);

`default_nettype wire
